// ===== design/membership_failure_detector_defines.svh =====
// Assertion macros for the membership failure detector.
`ifndef MEMBERSHIP_FAILURE_DETECTOR_DEFINES_SVH
`define MEMBERSHIP_FAILURE_DETECTOR_DEFINES_SVH
// Same-cycle implication, sampled on clk, off in reset.
`define MFD_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
// Next-cycle implication, sampled on clk, off in reset.
`define MFD_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== design/mfd_pkg.sv =====
// Types and codes shared by the membership failure detector modules.
package mfd_pkg;
  localparam logic [2:0] FUNC_START     = 3'd0;
  localparam logic [2:0] FUNC_JOIN_REQ  = 3'd1;
  localparam logic [2:0] FUNC_JOIN_REP  = 3'd2;
  localparam logic [2:0] FUNC_LIST      = 3'd3;
  localparam logic [2:0] FUNC_PING_REQ  = 3'd4;
  localparam logic [2:0] FUNC_PING_REP  = 3'd5;
  localparam logic [2:0] FUNC_TICK      = 3'd6;

  localparam logic [2:0] MSG_JOIN_REQ   = 3'd0;
  localparam logic [2:0] MSG_JOIN_REP   = 3'd1;
  localparam logic [2:0] MSG_LIST       = 3'd2;
  localparam logic [2:0] MSG_PING_REQ   = 3'd3;
  localparam logic [2:0] MSG_PING_REP   = 3'd4;

  localparam logic [2:0] CFG_SELF_ID    = 3'd0;
  localparam logic [2:0] CFG_SELF_PORT  = 3'd1;
  localparam logic [2:0] CFG_INTRO_ID   = 3'd2;
  localparam logic [2:0] CFG_INTRO_PORT = 3'd3;
  localparam logic [2:0] CFG_OWN_BEAT   = 3'd4;
  localparam logic [2:0] CFG_FAIL_TO    = 3'd5;
  localparam logic [2:0] CFG_REMOVE_TO  = 3'd6;

  localparam logic [5:0] MAX_MSGS = 6'd33;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] src_id;
    logic [15:0] src_port;
    logic [31:0] src_heartbeat;
    logic [31:0] item_id;
    logic [15:0] item_port;
    logic [31:0] item_heartbeat;
    logic [31:0] item_stamp;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic [2:0]  msg_kind;
    logic [31:0] dest_id;
    logic [15:0] dest_port;
    logic [31:0] out_id;
    logic [15:0] out_port;
    logic [31:0] out_heartbeat;
    logic [31:0] out_stamp;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] beat;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic suspect;
    logic live;
  } age_res_t;
endpackage

// ===== design/membership_failure_detector.sv =====
// Top level: membership table sequencer with failure detection.
// Usage:
//  - in channel (in_valid/in_ready/in_data): one event per request; in_ready
//    is high only while the sequencer is idle.
//  - out channel (out_valid/out_ready/out_data): messages in order, last set
//    on the final one of an event; an output register plus one staged
//    message part the sequencer from the receiver.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready.
// A list entry that names this node is ignored, one not yet in the table is
//  appended. A tick does nothing out of group; a removal shifts the later
//  entries down and then re-sorts the table by id in bubble sort passes,
//  all through the single table RAM.
// Reset clears the table count, in_group and the channels; config registers
//  take their reset values. The table RAM holds no reset.
// A stalled receiver holds the sequencer at its next message.
module membership_failure_detector import mfd_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  `include "membership_failure_detector_defines.svh"

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_HDR, S_APP_SELF, S_APP, S_LIST, S_LIST_W, S_SCAN, S_SCAN_W,
    S_SCAN_END, S_TICK, S_TICK_W, S_SH, S_SH_W, S_B0, S_BRD, S_BA, S_BB,
    S_BBW, S_BSW, S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  in_t           req_r, req_nxt;
  logic [CW-1:0] count_r, count_nxt, idx_r, idx_nxt;
  logic          in_group_r, in_group_nxt, found_r, found_nxt;
  logic          swapped_r, swapped_nxt;
  logic [5:0]    n_r, n_nxt;
  logic          pend_valid_r, pend_valid_nxt, out_valid_r, out_valid_nxt;
  out_t          pend_r, pend_nxt, out_r, out_nxt;
  entry_t        a_r, a_nxt;

  logic [31:0] self_id_r, intro_id_r, own_beat_r;
  logic [15:0] self_port_r, intro_port_r, fail_to_r, remove_to_r;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic [111:0]  rdata_raw;

  logic [31:0] alu_stamp;
  age_res_t    alu_res;

  logic   emit_req, can_emit, emit_ok;
  out_t   emit_msg;
  logic [CW-1:0] idx_p1;

  assign idx_p1 = idx_r + 1'b1;
  assign rdata = entry_t'(rdata_raw);
  assign raddr = (state_r == S_SH || state_r == S_SH_W || state_r == S_BB ||
                  state_r == S_BBW) ? idx_p1[IW-1:0] : idx_r[IW-1:0];

  mfd_ram #(.WIDTH(112), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );

  assign alu_stamp = (state_r == S_TICK_W) ? rdata.stamp : req_r.item_stamp;

  mfd_alu u_alu (
    .now(req_r.now), .stamp(alu_stamp), .fail_to(fail_to_r),
    .remove_to(remove_to_r), .res(alu_res)
  );

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign can_emit = !pend_valid_r || !out_valid_r || out_ready;
  assign emit_ok = !emit_req || (n_r >= MAX_MSGS) || can_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r <= '0;
      self_port_r <= '0;
      intro_id_r <= 32'd1;
      intro_port_r <= '0;
      own_beat_r <= '0;
      fail_to_r <= 16'd5;
      remove_to_r <= 16'd20;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SELF_ID:    self_id_r <= cfg_data;
        CFG_SELF_PORT:  self_port_r <= cfg_data[15:0];
        CFG_INTRO_ID:   intro_id_r <= cfg_data;
        CFG_INTRO_PORT: intro_port_r <= cfg_data[15:0];
        CFG_OWN_BEAT:   own_beat_r <= cfg_data;
        CFG_FAIL_TO:    fail_to_r <= cfg_data[15:0];
        CFG_REMOVE_TO:  remove_to_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic refresh, expired;
    state_nxt = state_r;
    req_nxt = req_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    in_group_nxt = in_group_r;
    found_nxt = found_r;
    swapped_nxt = swapped_r;
    n_nxt = n_r;
    a_nxt = a_r;
    we = 1'b0;
    waddr = idx_r[IW-1:0];
    wdata = rdata;
    emit_req = 1'b0;
    emit_msg = '0;
    refresh = 1'b0;
    expired = 1'b0;
    pend_nxt = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          n_nxt = '0;
          idx_nxt = '0;
          found_nxt = 1'b0;
          unique case (in_data.func)
            FUNC_START: begin
              count_nxt = '0;
              in_group_nxt = 1'b0;
              if (self_id_r == intro_id_r && self_port_r == intro_port_r) begin
                in_group_nxt = 1'b1;
                state_nxt = S_APP_SELF;
              end else begin
                state_nxt = S_HDR;
              end
            end
            FUNC_JOIN_REQ, FUNC_PING_REQ: state_nxt = S_HDR;
            FUNC_JOIN_REP: begin
              in_group_nxt = 1'b1;
              state_nxt = S_APP_SELF;
            end
            FUNC_LIST: state_nxt = (in_data.item_id == self_id_r) ? S_DONE : S_SCAN;
            FUNC_PING_REP: state_nxt = S_SCAN;
            FUNC_TICK: state_nxt = in_group_r ? S_TICK : S_DONE;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_HDR: begin
        emit_req = 1'b1;
        if (req_r.func == FUNC_START) begin
          emit_msg.msg_kind = MSG_JOIN_REQ;
          emit_msg.dest_id = intro_id_r;
          emit_msg.dest_port = intro_port_r;
        end else begin
          emit_msg.msg_kind = (req_r.func == FUNC_JOIN_REQ) ? MSG_JOIN_REP : MSG_PING_REP;
          emit_msg.dest_id = req_r.src_id;
          emit_msg.dest_port = req_r.src_port;
        end
        if (emit_ok) begin
          state_nxt = (req_r.func == FUNC_START) ? S_DONE : S_LIST;
        end
      end
      S_APP_SELF: begin
        if (count_r < DEPTH_C) begin
          we = 1'b1;
          waddr = count_r[IW-1:0];
          wdata = '{id: self_id_r, port: self_port_r, beat: own_beat_r,
                    stamp: req_r.now};
          count_nxt = count_r + 1'b1;
        end
        state_nxt = (req_r.func == FUNC_JOIN_REP) ? S_APP : S_DONE;
      end
      S_APP: begin
        if (count_r < DEPTH_C) begin
          we = 1'b1;
          waddr = count_r[IW-1:0];
          if (req_r.func == FUNC_LIST) begin
            wdata = '{id: req_r.item_id, port: req_r.item_port,
                      beat: req_r.item_heartbeat, stamp: req_r.item_stamp};
          end else begin
            wdata = '{id: req_r.src_id, port: req_r.src_port,
                      beat: req_r.src_heartbeat, stamp: req_r.now};
          end
          count_nxt = count_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_LIST: begin
        if (idx_r >= count_r) begin
          state_nxt = (req_r.func == FUNC_JOIN_REQ) ? S_APP : S_DONE;
        end else begin
          state_nxt = S_LIST_W;
        end
      end
      S_LIST_W: begin
        emit_req = 1'b1;
        emit_msg.msg_kind = MSG_LIST;
        emit_msg.dest_id = req_r.src_id;
        emit_msg.dest_port = req_r.src_port;
        emit_msg.out_id = rdata.id;
        emit_msg.out_port = rdata.port;
        emit_msg.out_heartbeat = rdata.beat;
        emit_msg.out_stamp = rdata.stamp;
        if (emit_ok) begin
          idx_nxt = idx_p1;
          state_nxt = S_LIST;
        end
      end
      S_SCAN: state_nxt = (idx_r >= count_r) ? S_SCAN_END : S_SCAN_W;
      S_SCAN_W: begin
        if (req_r.func == FUNC_LIST) begin
          if (rdata.id == req_r.item_id) begin
            found_nxt = 1'b1;
            if (rdata.stamp < req_r.item_stamp && alu_res.live) begin
              we = 1'b1;
              wdata.stamp = req_r.item_stamp;
              wdata.beat = req_r.item_heartbeat;
            end
          end
        end else if (rdata.id == req_r.src_id) begin
          we = 1'b1;
          wdata.stamp = req_r.now;
        end
        idx_nxt = idx_p1;
        state_nxt = S_SCAN;
      end
      S_SCAN_END: state_nxt = (req_r.func == FUNC_LIST && !found_r) ? S_APP : S_DONE;
      S_TICK: state_nxt = (idx_r >= count_r) ? S_DONE : S_TICK_W;
      S_TICK_W: begin
        if (alu_res.suspect) begin
          if (rdata.id == self_id_r) begin
            refresh = 1'b1;
          end else begin
            emit_req = 1'b1;
            emit_msg.msg_kind = MSG_PING_REQ;
            emit_msg.dest_id = rdata.id;
            emit_msg.dest_port = rdata.port;
          end
        end
        expired = refresh ? (remove_to_r == 16'd0) : !alu_res.live;
        if (emit_ok) begin
          if (refresh) begin
            we = 1'b1;
            wdata.stamp = req_r.now;
          end
          if (expired) begin
            state_nxt = S_SH;
          end else begin
            idx_nxt = idx_p1;
            state_nxt = S_TICK;
          end
        end
      end
      S_SH: begin
        if (idx_p1 < count_r) begin
          state_nxt = S_SH_W;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_B0;
        end
      end
      S_SH_W: begin
        we = 1'b1;
        idx_nxt = idx_p1;
        state_nxt = S_SH;
      end
      S_B0: begin
        idx_nxt = '0;
        swapped_nxt = 1'b0;
        state_nxt = S_BRD;
      end
      S_BRD: begin
        if (idx_p1 >= count_r) begin
          state_nxt = swapped_r ? S_B0 : S_DONE;
        end else begin
          state_nxt = S_BA;
        end
      end
      S_BA: begin
        a_nxt = rdata;
        state_nxt = S_BB;
      end
      S_BB: state_nxt = S_BBW;
      S_BBW: begin
        if (a_r.id > rdata.id) begin
          we = 1'b1;
          wdata = rdata;
          swapped_nxt = 1'b1;
          state_nxt = S_BSW;
        end else begin
          idx_nxt = idx_p1;
          state_nxt = S_BRD;
        end
      end
      S_BSW: begin
        we = 1'b1;
        waddr = idx_p1[IW-1:0];
        wdata = a_r;
        idx_nxt = idx_p1;
        state_nxt = S_BRD;
      end
      S_DONE: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_nxt = pend_r;
          out_nxt.last = 1'b1;
          out_valid_nxt = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (emit_req && n_r < MAX_MSGS && can_emit) begin
      if (pend_valid_r) begin
        out_nxt = pend_r;
        out_valid_nxt = 1'b1;
      end
      pend_nxt = emit_msg;
      pend_valid_nxt = 1'b1;
      n_nxt = n_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      in_group_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      n_r <= '0;
      idx_r <= '0;
      found_r <= 1'b0;
      swapped_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      in_group_r <= in_group_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r <= out_valid_nxt;
      n_r <= n_nxt;
      idx_r <= idx_nxt;
      found_r <= found_nxt;
      swapped_r <= swapped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    pend_r <= pend_nxt;
    out_r <= out_nxt;
    a_r <= a_nxt;
  end

  `MFD_ASSERT_IMPL(a_idle_no_pend, in_ready, !pend_valid_r)
  `MFD_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= DEPTH_C)
  `MFD_ASSERT_IMPL(a_msg_cap, 1'b1, n_r <= MAX_MSGS)
  `MFD_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
endmodule

// ===== design/mfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mfd_ram #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/mfd_alu.sv =====
// Shared age unit: modular age and timeout compares.
module mfd_alu import mfd_pkg::*; (
  input  logic [31:0] now,
  input  logic [31:0] stamp,
  input  logic [15:0] fail_to,
  input  logic [15:0] remove_to,
  output age_res_t    res
);
  logic [31:0] age;

  assign age = now - stamp;
  assign res.live = age < {16'd0, remove_to};
  assign res.suspect = (age >= {16'd0, fail_to}) && res.live;
endmodule
